// ===== rtl/core/wss_pkg.sv =====
package wss_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_WEIGHT_BITS = 32;

    localparam int TOTAL_W = 42;
    localparam int SCORE_W = 43;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_SAMPLE = 2'd1,
        K_EMPTY  = 2'd2,
        K_FULL   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [30:0]        pos;
        logic [7:0]         ref_a;
        logic [7:0]         alt_a;
        logic [31:0]        weight;
        logic signed [15:0] offset;
        logic signed [31:0] score;
    } t_site_rec;

    typedef struct packed {
        logic  capture;
        logic  add_wr;
        logic  scale;
        logic  target;
        logic  step;
        logic  out_load;
        t_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic search_open;
    } t_dp_stat;

endpackage

// ===== rtl/core/wss_ctrl.sv =====
module wss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    output logic              o_valid,
    input  logic              i_ready,
    input  wss_pkg::t_dp_stat i_stat,
    output wss_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADD    = 7'b0000010,
        S_SCALE  = 7'b0000100,
        S_TGT    = 7'b0001000,
        S_SRD    = 7'b0010000,
        S_SCMP   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    wss_pkg::t_kind r_kind, n_kind;
    logic          r_out_valid;
    logic          accept;
    logic          load;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign load    = (r_state == S_RESULT) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_action) begin
                        if (i_stat.full) begin
                            n_kind  = wss_pkg::K_FULL;
                            n_state = S_RESULT;
                        end else begin
                            n_kind  = wss_pkg::K_ADD;
                            n_state = S_ADD;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            n_kind  = wss_pkg::K_EMPTY;
                            n_state = S_RESULT;
                        end else begin
                            n_kind  = wss_pkg::K_SAMPLE;
                            n_state = S_SCALE;
                        end
                    end
                end
            end
            S_ADD:    n_state = S_RESULT;
            S_SCALE:  n_state = S_TGT;
            S_TGT:    n_state = S_SRD;
            S_SRD:    n_state = i_stat.search_open ? S_SCMP : S_RESULT;
            S_SCMP:   n_state = S_SRD;
            S_RESULT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= wss_pkg::K_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.capture  = accept;
        o_cmd.add_wr   = (r_state == S_ADD);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.target   = (r_state == S_TGT);
        o_cmd.step     = (r_state == S_SCMP);
        o_cmd.out_load = load;
        o_cmd.kind     = r_kind;
    end

endmodule

// ===== rtl/core/wss_datapath.sv =====
module wss_datapath #(
    parameter int MAX_ENTRIES = wss_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = wss_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wss_pkg::t_dp_cmd              i_cmd,
    output wss_pkg::t_dp_stat             o_stat,
    input  logic [30:0]                   i_site_position,
    input  logic [31:0]                   i_site_weight,
    input  logic [7:0]                    i_ref_allele,
    input  logic [7:0]                    i_alt_allele,
    input  logic signed [15:0]            i_base_offset,
    input  logic signed [31:0]            i_site_score,
    input  logic [31:0]                   i_random_fraction,
    output logic [1:0]                    o_status,
    output logic [9:0]                    o_chosen_index,
    output logic [30:0]                   o_chosen_position,
    output logic [7:0]                    o_chosen_ref,
    output logic [7:0]                    o_chosen_alt,
    output logic [31:0]                   o_chosen_weight,
    output logic signed [15:0]            o_chosen_offset,
    output logic signed [31:0]            o_chosen_score,
    output logic [wss_pkg::TOTAL_W-1:0]   o_total_weight,
    output logic signed [wss_pkg::SCORE_W-1:0] o_total_score,
    output logic [10:0]                   o_entry_count
);

    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int WSTORE_W = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
    localparam int TW       = wss_pkg::TOTAL_W;
    localparam int SW       = wss_pkg::SCORE_W;

    logic [TW-1:0]          cum_mem [MAX_ENTRIES];
    wss_pkg::t_site_rec     rec_mem [MAX_ENTRIES];

    logic [CNT_W-1:0]       r_count;
    logic [TW-1:0]          r_total;
    logic signed [SW-1:0]   r_score_sum;

    logic [30:0]            r_pos;
    logic [31:0]            r_wt;
    logic [7:0]             r_ref;
    logic [7:0]             r_alt;
    logic signed [15:0]     r_off;
    logic signed [31:0]     r_score;
    logic [31:0]            r_frac;

    logic [63:0]            r_prod_lo;
    logic [TW-1:0]          r_prod_hi;
    logic [TW-1:0]          r_target;
    logic [IDX_W-1:0]       r_lo;
    logic [IDX_W-1:0]       r_hi;
    logic [IDX_W-1:0]       mid;
    logic [TW-1:0]          r_cum_q;
    wss_pkg::t_site_rec     r_rec_q;

    logic [TW:0]            wsum;
    logic [TW-1:0]          n_total;
    logic signed [SW:0]     ssum;
    logic signed [SW-1:0]   n_score_sum;
    wss_pkg::t_site_rec     wr_rec;
    logic                   is_sample;

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    assign wsum    = {1'b0, r_total} + (TW + 1)'(r_wt);
    assign n_total = wsum[TW] ? wss_pkg::TOTAL_MAX : wsum[TW-1:0];

    assign ssum = (SW + 1)'(r_score_sum) + (SW + 1)'(r_score);
    always_comb begin
        if (ssum[SW] != ssum[SW-1]) begin
            n_score_sum = ssum[SW] ? wss_pkg::SCORE_MIN : wss_pkg::SCORE_MAX;
        end else begin
            n_score_sum = ssum[SW-1:0];
        end
    end

    always_comb begin
        wr_rec.pos    = r_pos;
        wr_rec.ref_a  = r_ref;
        wr_rec.alt_a  = r_alt;
        wr_rec.weight = r_wt;
        wr_rec.offset = r_off;
        wr_rec.score  = r_score;
    end

    always_comb begin
        o_stat.empty       = (r_count == '0);
        o_stat.full        = (r_count == CNT_W'(MAX_ENTRIES));
        o_stat.search_open = (r_lo < r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            cum_mem[r_count[IDX_W-1:0]] <= n_total;
            rec_mem[r_count[IDX_W-1:0]] <= wr_rec;
        end
        r_cum_q <= cum_mem[mid];
        r_rec_q <= rec_mem[r_lo];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_score_sum <= '0;
        end else if (i_cmd.add_wr) begin
            r_count     <= r_count + CNT_W'(1);
            r_total     <= n_total;
            r_score_sum <= n_score_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos   <= i_site_position;
            r_wt    <= 32'(i_site_weight[WSTORE_W-1:0]);
            r_ref   <= i_ref_allele;
            r_alt   <= i_alt_allele;
            r_off   <= i_base_offset;
            r_score <= i_site_score;
            r_frac  <= i_random_fraction;
        end
        if (i_cmd.scale) begin
            r_prod_lo <= 64'(r_frac) * 64'(r_total[31:0]);
            r_prod_hi <= TW'(r_frac) * TW'(r_total[TW-1:32]);
        end
        if (i_cmd.target) begin
            r_target <= r_prod_hi + TW'(r_prod_lo[63:32]);
            r_lo     <= '0;
            r_hi     <= IDX_W'(r_count - CNT_W'(1));
        end else if (i_cmd.step) begin
            if (r_cum_q >= r_target) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + IDX_W'(1);
            end
        end
    end

    assign is_sample = (i_cmd.kind == wss_pkg::K_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.kind)
                wss_pkg::K_EMPTY: o_status <= wss_pkg::ST_EMPTY;
                wss_pkg::K_FULL:  o_status <= wss_pkg::ST_FULL;
                default:          o_status <= wss_pkg::ST_OK;
            endcase
            o_chosen_index    <= is_sample ? 10'(r_lo) : '0;
            o_chosen_position <= is_sample ? r_rec_q.pos : '0;
            o_chosen_ref      <= is_sample ? r_rec_q.ref_a : '0;
            o_chosen_alt      <= is_sample ? r_rec_q.alt_a : '0;
            o_chosen_weight   <= is_sample ? r_rec_q.weight : '0;
            o_chosen_offset   <= is_sample ? r_rec_q.offset : '0;
            o_chosen_score    <= is_sample ? r_rec_q.score : '0;
            o_total_weight    <= r_total;
            o_total_score     <= r_score_sum;
            o_entry_count     <= 11'(r_count);
        end
    end

endmodule

// ===== rtl/core/weighted_site_sampler_top.sv =====
// weighted site sampler: an add request appends a site record and its running cumulative
// weight to on-chip tables, a sample request scales a Q0.32 fraction by the total weight
// and binary-searches the cumulative table for the first entry at or above that target.
// every request gives one result; one request is worked on at a time, and a new one is
// taken while the previous result still waits in the output register. an add passes
// through the add and result states; a rejected add or a sample on an empty table goes
// straight to the result state. a sample scales the fraction, forms the target, then
// searches; each step is a registered read of the cumulative weight table and a compare.
module weighted_site_sampler_top #(
    parameter int MAX_ENTRIES = wss_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = wss_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_action,
    input  logic [30:0]                        i_site_position,
    input  logic [31:0]                        i_site_weight,
    input  logic [7:0]                         i_ref_allele,
    input  logic [7:0]                         i_alt_allele,
    input  logic signed [15:0]                 i_base_offset,
    input  logic signed [31:0]                 i_site_score,
    input  logic [31:0]                        i_random_fraction,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [9:0]                         o_chosen_index,
    output logic [30:0]                        o_chosen_position,
    output logic [7:0]                         o_chosen_ref,
    output logic [7:0]                         o_chosen_alt,
    output logic [31:0]                        o_chosen_weight,
    output logic signed [15:0]                 o_chosen_offset,
    output logic signed [31:0]                 o_chosen_score,
    output logic [wss_pkg::TOTAL_W-1:0]        o_total_weight,
    output logic signed [wss_pkg::SCORE_W-1:0] o_total_score,
    output logic [10:0]                        o_entry_count
);

    wss_pkg::t_dp_cmd  cmd;
    wss_pkg::t_dp_stat stat;

    wss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_action(i_action),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wss_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_site_position   (i_site_position),
        .i_site_weight     (i_site_weight),
        .i_ref_allele      (i_ref_allele),
        .i_alt_allele      (i_alt_allele),
        .i_base_offset     (i_base_offset),
        .i_site_score      (i_site_score),
        .i_random_fraction (i_random_fraction),
        .o_status          (o_status),
        .o_chosen_index    (o_chosen_index),
        .o_chosen_position (o_chosen_position),
        .o_chosen_ref      (o_chosen_ref),
        .o_chosen_alt      (o_chosen_alt),
        .o_chosen_weight   (o_chosen_weight),
        .o_chosen_offset   (o_chosen_offset),
        .o_chosen_score    (o_chosen_score),
        .o_total_weight    (o_total_weight),
        .o_total_score     (o_total_score),
        .o_entry_count     (o_entry_count)
    );

endmodule

// ===== test/weighted_site_sampler_top_test.sv =====
module weighted_site_sampler_top_test;

    localparam int MAX_SITES    = wss_pkg::DEF_MAX_ENTRIES;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        wss_pkg::t_status                   status;
        logic [9:0]                         index;
        wss_pkg::t_site_rec                 rec;
        logic [wss_pkg::TOTAL_W-1:0]        total_w;
        logic signed [wss_pkg::SCORE_W-1:0] total_s;
        logic [10:0]                        count;
    } t_site_result;

    logic                               i_clk             = 1'b0;
    logic                               i_rst_n           = 1'b0;
    logic                               i_valid           = 1'b0;
    logic                               o_ready;
    logic                               i_action          = 1'b0;
    logic [30:0]                        i_site_position   = '0;
    logic [31:0]                        i_site_weight     = '0;
    logic [7:0]                         i_ref_allele      = '0;
    logic [7:0]                         i_alt_allele      = '0;
    logic signed [15:0]                 i_base_offset     = '0;
    logic signed [31:0]                 i_site_score      = '0;
    logic [31:0]                        i_random_fraction = '0;
    logic                               o_valid;
    logic                               i_ready           = 1'b0;
    logic [1:0]                         o_status;
    logic [9:0]                         o_chosen_index;
    logic [30:0]                        o_chosen_position;
    logic [7:0]                         o_chosen_ref;
    logic [7:0]                         o_chosen_alt;
    logic [31:0]                        o_chosen_weight;
    logic signed [15:0]                 o_chosen_offset;
    logic signed [31:0]                 o_chosen_score;
    logic [wss_pkg::TOTAL_W-1:0]        o_total_weight;
    logic signed [wss_pkg::SCORE_W-1:0] o_total_score;
    logic [10:0]                        o_entry_count;

    // predicted table contents
    logic [wss_pkg::TOTAL_W-1:0]        cum_weight [MAX_SITES];
    wss_pkg::t_site_rec                 site_table [MAX_SITES];
    int unsigned                        site_count  = 0;
    logic signed [wss_pkg::SCORE_W-1:0] score_total = '0;

    t_site_result pending_results[$];
    int           mismatches     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_goal      = 0;
    int           held_cycles    = 0;
    int           quiet_cycles   = 0;

    weighted_site_sampler_top dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic t_site_result predict_site_result(input logic act,
                                                         input wss_pkg::t_site_rec rec,
                                                         input logic [31:0] frac);
        t_site_result                       res;
        logic [wss_pkg::TOTAL_W:0]          cum_sum;
        logic signed [wss_pkg::SCORE_W:0]   score_wide;
        logic [wss_pkg::TOTAL_W-1:0]        total;
        logic [73:0]                        product;
        logic [wss_pkg::TOTAL_W-1:0]        target;
        int unsigned                        lo;
        int unsigned                        hi;
        int unsigned                        mid;
        res = '0;
        res.status = wss_pkg::ST_OK;
        total = (site_count == 0) ? '0 : cum_weight[site_count-1];
        if (act == ACT_ADD) begin
            if (site_count >= MAX_SITES) begin
                res.status = wss_pkg::ST_FULL;
            end else begin
                cum_sum = {1'b0, total} + rec.weight;
                cum_weight[site_count] = (cum_sum > wss_pkg::TOTAL_MAX) ? wss_pkg::TOTAL_MAX
                                                  : cum_sum[wss_pkg::TOTAL_W-1:0];
                site_table[site_count] = rec;
                score_wide = score_total;
                score_wide = score_wide + $signed(rec.score);
                if (score_wide > wss_pkg::SCORE_MAX) begin
                    score_total = wss_pkg::SCORE_MAX;
                end else if (score_wide < wss_pkg::SCORE_MIN) begin
                    score_total = wss_pkg::SCORE_MIN;
                end else begin
                    score_total = score_wide[wss_pkg::SCORE_W-1:0];
                end
                site_count++;
            end
        end else if (site_count == 0) begin
            res.status = wss_pkg::ST_EMPTY;
        end else begin
            product = 74'(frac) * 74'(total);
            target = product[73:32];
            lo = 0;
            hi = site_count - 1;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (cum_weight[mid] >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            res.index = lo[9:0];
            res.rec = site_table[lo];
        end
        res.total_w = (site_count == 0) ? '0 : cum_weight[site_count-1];
        res.total_s = score_total;
        res.count = site_count[10:0];
        return res;
    endfunction

    function automatic wss_pkg::t_site_rec random_site();
        wss_pkg::t_site_rec rec;
        rec.pos = 31'($urandom);
        case ($urandom_range(7))
            0: rec.weight = '0;
            1: rec.weight = 32'($urandom_range(15));
            default: rec.weight = $urandom;
        endcase
        rec.ref_a = 8'($urandom);
        rec.alt_a = 8'($urandom);
        rec.offset = 16'($urandom);
        rec.score = $urandom;
        return rec;
    endfunction

    function automatic logic [31:0] draw_fraction();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            report_mismatch(what, want, got);
        end
    endfunction

    function automatic void check_result();
        t_site_result exp;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", '0, {o_status});
        end else begin
            exp = pending_results.pop_front();
            compare_field("status", {exp.status}, {o_status});
            compare_field("chosen_index", {exp.index}, {o_chosen_index});
            compare_field("chosen_position", {exp.rec.pos}, {o_chosen_position});
            compare_field("chosen_ref", {exp.rec.ref_a}, {o_chosen_ref});
            compare_field("chosen_alt", {exp.rec.alt_a}, {o_chosen_alt});
            compare_field("chosen_weight", {exp.rec.weight}, {o_chosen_weight});
            compare_field("chosen_offset", {exp.rec.offset}, {o_chosen_offset});
            compare_field("chosen_score", {exp.rec.score}, {o_chosen_score});
            compare_field("total_weight", {exp.total_w}, {o_total_weight});
            compare_field("total_score", {exp.total_s}, {o_total_score});
            compare_field("entry_count", {exp.count}, {o_entry_count});
        end
    endfunction

    task automatic send_request(input logic act, input wss_pkg::t_site_rec rec,
                                input logic [31:0] frac);
        t_site_result exp_res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= act;
        i_site_position   <= rec.pos;
        i_site_weight     <= rec.weight;
        i_ref_allele      <= rec.ref_a;
        i_alt_allele      <= rec.alt_a;
        i_base_offset     <= rec.offset;
        i_site_score      <= rec.score;
        i_random_fraction <= frac;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        exp_res = predict_site_result(act, rec, frac);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic test_directed_extremes();
        wss_pkg::t_site_rec low_rec;
        wss_pkg::t_site_rec high_rec;
        wss_pkg::t_site_rec mid_rec;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        low_rec = '0;
        low_rec.offset = 16'h8000;
        low_rec.score = 32'h8000_0000;
        high_rec = '1;
        high_rec.offset = 16'h7fff;
        high_rec.score = 32'h7fff_ffff;
        send_request(ACT_SAMPLE, high_rec, $urandom);
        send_request(ACT_ADD, low_rec, '1);
        // zero total weight
        send_request(ACT_SAMPLE, high_rec, '1);
        send_request(ACT_ADD, high_rec, '0);
        mid_rec = random_site();
        mid_rec.weight = '0;
        send_request(ACT_ADD, mid_rec, '0);
        mid_rec = random_site();
        mid_rec.weight = 32'd1;
        send_request(ACT_ADD, mid_rec, '0);
        send_request(ACT_SAMPLE, low_rec, '0);
        send_request(ACT_SAMPLE, low_rec, '1);
        send_request(ACT_SAMPLE, low_rec, 32'h8000_0000);
        send_request(ACT_SAMPLE, low_rec, 32'd1);
        send_request(ACT_ADD, low_rec, '0);
        send_request(ACT_ADD, high_rec, '1);
        send_request(ACT_SAMPLE, random_site(), $urandom);
        send_request(ACT_SAMPLE, random_site(), $urandom);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_requests);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_requests) begin
            if ($urandom_range(99) < 70) begin
                send_request(ACT_ADD, random_site(), $urandom);
            end else begin
                send_request(ACT_SAMPLE, random_site(), draw_fraction());
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_goal <= hold_goal + HOLD_CYCLES;
        repeat (30) begin
            send_request($urandom_range(1) ? ACT_SAMPLE : ACT_ADD, random_site(),
                         draw_fraction());
        end
    endtask

    task automatic test_table_full();
        send_idle_pct = 29;
        recv_stall_pct = 29;
        while (site_count < MAX_SITES) begin
            send_request(ACT_ADD, random_site(), $urandom);
        end
        repeat (4) begin
            send_request(ACT_ADD, random_site(), $urandom);
            send_request(ACT_SAMPLE, random_site(), draw_fraction());
        end
        send_request(ACT_SAMPLE, random_site(), '0);
        send_request(ACT_SAMPLE, random_site(), '1);
    endtask

    always @(posedge i_clk) begin
        if (held_cycles < hold_goal) begin
            i_ready <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            check_result();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[weighted_site_sampler_top] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_random_traffic(0, 0, 100);
        test_random_traffic(47, 0, 100);
        test_random_traffic(0, 47, 100);
        test_random_traffic(29, 29, 100);
        test_output_backpressure();
        test_table_full();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[weighted_site_sampler_top] OK");
        end else begin
            $display("[weighted_site_sampler_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/wss_pkg.sv
rtl/core/wss_ctrl.sv
rtl/core/wss_datapath.sv
rtl/core/weighted_site_sampler_top.sv
test/weighted_site_sampler_top_test.sv
